FILE: rtl/bucket_priority_queue_assert.svh
// Assertion macros used by the queue top level.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BUCKET_PRIORITY_QUEUE_ASSERT_SVH
`define BUCKET_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bpq_pkg.sv
package bpq_pkg;

  localparam int DIST_W   = 8;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // ring store control and status
  typedef struct packed {
    logic push;
    logic pop;
    logic sel;
  } ring_req_t;

  typedef struct packed {
    logic [1:0] empty;
    logic [1:0] full;
  } ring_stat_t;

  // spill store control and status
  typedef struct packed {
    logic push;
    logic pop;
  } spill_req_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic done;
  } spill_stat_t;

endpackage

FILE: rtl/bpq_in_if.sv
interface bpq_in_if #(
  parameter int HANDLE_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [HANDLE_WIDTH-1:0]     node_handle;
  logic [bpq_pkg::DIST_W-1:0]  distance;

  modport source (output valid, operation, node_handle, distance, input ready);
  modport sink   (input valid, operation, node_handle, distance, output ready);
endinterface

FILE: rtl/bpq_out_if.sv
interface bpq_out_if #(
  parameter int HANDLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [bpq_pkg::STATUS_W-1:0]  status;
  logic [HANDLE_WIDTH-1:0]       popped_handle;
  logic [bpq_pkg::DIST_W-1:0]    popped_distance;

  modport source (output valid, status, popped_handle, popped_distance, input ready);
  modport sink   (input valid, status, popped_handle, popped_distance, output ready);
endinterface

FILE: rtl/bpq_ring_store.sv
module bpq_ring_store #(
  parameter int RING_DEPTH   = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bpq_pkg::ring_req_t      req,
  input  logic [HANDLE_WIDTH-1:0] push_handle,
  output bpq_pkg::ring_stat_t     stat,
  output logic [HANDLE_WIDTH-1:0] pop_handle
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int AW = $clog2(2 * RING_DEPTH);

  // both rings share one memory: ring 1 sits above ring 0
  logic [HANDLE_WIDTH-1:0] mem [2 * RING_DEPTH];
  logic [PW-1:0]           head [2];
  logic [PW-1:0]           tail [2];
  logic [PW-1:0]           cur_head;
  logic [PW-1:0]           cur_tail;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_addr(input logic sel, input logic [PW-1:0] p);
    return AW'(p) + (sel ? AW'(RING_DEPTH) : '0);
  endfunction

  assign cur_head = req.sel ? head[1] : head[0];
  assign cur_tail = req.sel ? tail[1] : tail[0];
  assign waddr    = ring_addr(req.sel, cur_tail);
  assign raddr    = ring_addr(req.sel, cur_head);

  // per-ring flags; full keeps one slot free
  for (genvar r = 0; r < 2; r++) begin : g_stat
    assign stat.empty[r] = (head[r] == tail[r]);
    assign stat.full[r]  = (ptr_next(tail[r]) == head[r]);
  end

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[waddr] <= push_handle;
    end
    if (req.pop) begin
      pop_handle <= mem[raddr];
    end
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head[0] <= '0;
      head[1] <= '0;
      tail[0] <= '0;
      tail[1] <= '0;
    end else begin
      if (req.push) begin
        if (req.sel) begin
          tail[1] <= ptr_next(cur_tail);
        end else begin
          tail[0] <= ptr_next(cur_tail);
        end
      end
      if (req.pop) begin
        if (req.sel) begin
          head[1] <= ptr_next(cur_head);
        end else begin
          head[0] <= ptr_next(cur_head);
        end
      end
    end
  end

endmodule

FILE: rtl/bpq_spill_store.sv
module bpq_spill_store #(
  parameter int SPILL_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bpq_pkg::spill_req_t          req,
  input  logic [HANDLE_WIDTH-1:0]      push_handle,
  input  logic [bpq_pkg::DIST_W-1:0]   push_distance,
  output bpq_pkg::spill_stat_t         stat,
  output logic [HANDLE_WIDTH-1:0]      pop_handle,
  output logic [bpq_pkg::DIST_W-1:0]   pop_distance
);

  localparam int DW = bpq_pkg::DIST_W;
  localparam int SW = (SPILL_DEPTH > 1) ? $clog2(SPILL_DEPTH) : 1;
  localparam int CW = $clog2(SPILL_DEPTH + 1);
  localparam int EW = HANDLE_WIDTH + DW;

  typedef enum logic [2:0] {
    SP_IDLE  = 3'b001,
    SP_SCAN  = 3'b010,
    SP_SHIFT = 3'b100
  } sp_state_t;

  sp_state_t state;

  // entry = {handle, distance}
  logic [EW-1:0]           mem [SPILL_DEPTH];
  logic [EW-1:0]           rdata;
  logic                    rd_en;
  logic [SW-1:0]           rd_addr;
  logic                    wr_en;
  logic [SW-1:0]           wr_addr;
  logic [EW-1:0]           wdata;

  logic [CW-1:0]           count;
  logic [CW-1:0]           count_m1;
  logic [CW-1:0]           iss;        // next index to read
  logic [CW-1:0]           didx;       // index of the data on the read port
  logic [CW-1:0]           didx_m1;
  logic                    vld;        // read data valid this cycle
  logic                    first;
  logic                    done;
  logic [CW-1:0]           best_idx;
  logic [CW-1:0]           sel_idx;
  logic [CW-1:0]           shift_start;
  logic                    scan_hit;
  logic                    last;
  logic                    more;

  assign count_m1    = count - CW'(1);
  assign didx_m1     = didx - CW'(1);
  assign last        = vld && (didx == count_m1);
  assign more        = (iss < count);
  // strict less keeps the earliest entry on ties
  assign scan_hit    = vld && (first || (rdata[DW-1:0] < pop_distance));
  assign sel_idx     = scan_hit ? didx : best_idx;
  assign shift_start = sel_idx + CW'(1);

  assign stat.full  = (count == CW'(SPILL_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.done  = done;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = iss[SW-1:0];
    wr_en   = 1'b0;
    wr_addr = count[SW-1:0];
    wdata   = {push_handle, push_distance};
    case (state)
      SP_IDLE: begin
        if (req.push) begin
          wr_en = 1'b1;
        end
        if (req.pop) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      SP_SCAN: begin
        if (more) begin
          rd_en = 1'b1;
        end else if (last && (sel_idx != count_m1)) begin
          rd_en   = 1'b1;
          rd_addr = shift_start[SW-1:0];
        end
      end
      SP_SHIFT: begin
        if (vld) begin
          wr_en   = 1'b1;
          wr_addr = didx_m1[SW-1:0];
          wdata   = rdata;
        end
        if (more) begin
          rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // best-entry tracking during the scan
  always_ff @(posedge clk) begin
    if (state == SP_SCAN && scan_hit) begin
      best_idx     <= didx;
      pop_handle   <= rdata[EW-1:DW];
      pop_distance <= rdata[DW-1:0];
    end
  end

  // scan and shift sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SP_IDLE;
      count <= '0;
      vld   <= 1'b0;
      done  <= 1'b0;
      first <= 1'b0;
      iss   <= '0;
      didx  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        SP_IDLE: begin
          if (req.push) begin
            count <= count + CW'(1);
          end
          if (req.pop) begin
            iss   <= CW'(1);
            didx  <= '0;
            vld   <= 1'b1;
            first <= 1'b1;
            state <= SP_SCAN;
          end
        end
        SP_SCAN: begin
          if (vld) begin
            first <= 1'b0;
          end
          if (more) begin
            iss  <= iss + CW'(1);
            didx <= iss;
            vld  <= 1'b1;
          end else begin
            vld <= 1'b0;
          end
          if (last) begin
            if (sel_idx == count_m1) begin
              // least entry is the top one: nothing to shift
              count <= count_m1;
              done  <= 1'b1;
              vld   <= 1'b0;
              state <= SP_IDLE;
            end else begin
              didx  <= shift_start;
              iss   <= shift_start + CW'(1);
              vld   <= 1'b1;
              state <= SP_SHIFT;
            end
          end
        end
        SP_SHIFT: begin
          if (more) begin
            iss  <= iss + CW'(1);
            didx <= iss;
            vld  <= 1'b1;
          end else begin
            vld <= 1'b0;
          end
          if (last) begin
            count <= count_m1;
            done  <= 1'b1;
            vld   <= 1'b0;
            state <= SP_IDLE;
          end
        end
        default: begin
          state <= SP_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/bucket_priority_queue.sv
// Push: result goes to the output register, or to the hold buffer while the output stalls.
// Ring pop: registered read of the shared ring memory, then the output register.
// Spill pop: the spill store scans its N entries for the least one, at place k, and then shifts the
//   entries above k down, one entry per cycle; the next item waits for the output register.
// Reset (rst, synchronous) clears ring pointers, spill count and control;
//   memory contents stay undefined and are never read before being written.
`include "bucket_priority_queue_assert.svh"

module bucket_priority_queue #(
  parameter int RING_DEPTH   = 64,
  parameter int SPILL_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  bpq_in_if.sink    in_item,
  bpq_out_if.source out_item
);

  localparam int DW = bpq_pkg::DIST_W;
  localparam int TW = bpq_pkg::STATUS_W;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_RING  = 4'b0010,
    T_SPILL = 4'b0100,
    T_HOLD  = 4'b1000
  } top_state_t;

  top_state_t state;
  top_state_t state_next;

  bpq_pkg::ring_req_t   ring_req;
  bpq_pkg::ring_stat_t  ring_stat;
  bpq_pkg::spill_req_t  spill_req;
  bpq_pkg::spill_stat_t spill_stat;

  logic [HANDLE_WIDTH-1:0] ring_handle;
  logic [HANDLE_WIDTH-1:0] spill_handle;
  logic [DW-1:0]           spill_distance;

  logic                    accept;
  logic                    out_free;
  logic                    ring_sel;
  logic                    out_valid;
  logic                    fin;
  logic [TW-1:0]           fin_status;
  logic [HANDLE_WIDTH-1:0] fin_handle;
  logic [DW-1:0]           fin_distance;
  logic [TW-1:0]           res_status;
  logic [HANDLE_WIDTH-1:0] res_handle;
  logic [DW-1:0]           res_distance;
  logic [TW-1:0]           out_status;
  logic [HANDLE_WIDTH-1:0] out_handle;
  logic [DW-1:0]           out_distance;

  assign in_item.ready            = (state == T_IDLE);
  assign accept                   = in_item.valid && in_item.ready;
  assign out_free                 = !out_valid || out_item.ready;
  assign out_item.valid           = out_valid;
  assign out_item.status          = out_status;
  assign out_item.popped_handle   = out_handle;
  assign out_item.popped_distance = out_distance;

  bpq_ring_store #(
    .RING_DEPTH   (RING_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .req         (ring_req),
    .push_handle (in_item.node_handle),
    .stat        (ring_stat),
    .pop_handle  (ring_handle)
  );

  bpq_spill_store #(
    .SPILL_DEPTH  (SPILL_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_spill (
    .clk           (clk),
    .rst           (rst),
    .req           (spill_req),
    .push_handle   (in_item.node_handle),
    .push_distance (in_item.distance),
    .stat          (spill_stat),
    .pop_handle    (spill_handle),
    .pop_distance  (spill_distance)
  );

  // dispatch and completion
  always_comb begin
    ring_req     = '0;
    spill_req    = '0;
    fin          = 1'b0;
    fin_status   = bpq_pkg::ST_DONE;
    fin_handle   = '0;
    fin_distance = '0;
    state_next   = state;
    case (state)
      T_IDLE: begin
        if (accept) begin
          if (in_item.operation == bpq_pkg::OP_PUSH) begin
            fin = 1'b1;
            if (in_item.distance == DW'(0)) begin
              if (ring_stat.full[0]) begin
                fin_status = bpq_pkg::ST_FULL;
              end else begin
                ring_req.push = 1'b1;
              end
            end else if (in_item.distance == DW'(1)) begin
              ring_req.sel = 1'b1;
              if (ring_stat.full[1]) begin
                fin_status = bpq_pkg::ST_FULL;
              end else begin
                ring_req.push = 1'b1;
              end
            end else if (spill_stat.full) begin
              fin_status = bpq_pkg::ST_FULL;
            end else begin
              spill_req.push = 1'b1;
            end
          end else if (!ring_stat.empty[0]) begin
            ring_req.pop = 1'b1;
            state_next   = T_RING;
          end else if (!ring_stat.empty[1]) begin
            ring_req.pop = 1'b1;
            ring_req.sel = 1'b1;
            state_next   = T_RING;
          end else if (!spill_stat.empty) begin
            spill_req.pop = 1'b1;
            state_next    = T_SPILL;
          end else begin
            fin        = 1'b1;
            fin_status = bpq_pkg::ST_EMPTY;
          end
        end
      end
      T_RING: begin
        fin          = 1'b1;
        fin_handle   = ring_handle;
        fin_distance = DW'(ring_sel);
      end
      T_SPILL: begin
        if (spill_stat.done) begin
          fin          = 1'b1;
          fin_handle   = spill_handle;
          fin_distance = spill_distance;
        end
      end
      T_HOLD: begin
        if (out_free) begin
          state_next = T_IDLE;
        end
      end
      default: begin
        state_next = T_IDLE;
      end
    endcase
    if (fin) begin
      state_next = out_free ? T_IDLE : T_HOLD;
    end
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_item.ready) begin
        out_valid <= 1'b0;
      end
      if ((fin || state == T_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload: output register and hold buffer
  always_ff @(posedge clk) begin
    if (ring_req.pop) begin
      ring_sel <= ring_req.sel;
    end
    if (fin && out_free) begin
      out_status   <= fin_status;
      out_handle   <= fin_handle;
      out_distance <= fin_distance;
    end else if (fin) begin
      res_status   <= fin_status;
      res_handle   <= fin_handle;
      res_distance <= fin_distance;
    end else if (state == T_HOLD && out_free) begin
      out_status   <= res_status;
      out_handle   <= res_handle;
      out_distance <= res_distance;
    end
  end

  `BPQ_ASSERT_IMPLY(a_ring_push_room, ring_req.push, !ring_stat.full[ring_req.sel], "ring push while full")
  `BPQ_ASSERT_IMPLY(a_spill_done_owned, spill_stat.done, state == T_SPILL, "spill done outside a spill pop")
  `BPQ_ASSERT_IMPLY(a_hold_blocked, state == T_HOLD, out_valid, "holding a result with a free output")
  `BPQ_ASSERT_NEXT(a_push_result, accept && in_item.operation == bpq_pkg::OP_PUSH, out_valid, "push result missing")

endmodule
